// ----- rtl/pmfp_pkg.sv -----
// ---------------------------------------------------------------------------
// pmfp_pkg: shared types and constants of the PM sensor frame parser
// Frame layout, field widths and the parser-to-ring frame record.
// ---------------------------------------------------------------------------
package pmfp_pkg;

   localparam int BYTE_W = 8;
   localparam int PM_W   = 16;
   localparam int AVG_W  = 20;
   localparam int POS_W  = 4;
   localparam int FRAC_W = 4;

   localparam logic [BYTE_W-1:0] FRAME_HEADER = 8'd170;

   // byte positions inside the ten-byte frame
   localparam logic [POS_W-1:0] POS_HEADER  = 4'd0;
   localparam logic [POS_W-1:0] POS_CMD     = 4'd1;
   localparam logic [POS_W-1:0] POS_PM25_LO = 4'd2;
   localparam logic [POS_W-1:0] POS_PM25_HI = 4'd3;
   localparam logic [POS_W-1:0] POS_PM10_LO = 4'd4;
   localparam logic [POS_W-1:0] POS_PM10_HI = 4'd5;
   localparam logic [POS_W-1:0] POS_ID_LO   = 4'd6;
   localparam logic [POS_W-1:0] POS_ID_HI   = 4'd7;
   localparam logic [POS_W-1:0] POS_CHECK   = 4'd8;
   localparam logic [POS_W-1:0] POS_TAIL    = 4'd9;

   typedef struct packed {
      logic            done;
      logic            ok;
      logic [PM_W-1:0] pm25;
      logic [PM_W-1:0] pm10;
   } frame_type;

endpackage

// ----- rtl/pmfp_parser.sv -----
// ---------------------------------------------------------------------------
// pmfp_parser: byte-serial frame parser
// Hunts for the header, assembles the PM words and checks the frame sum.
// ---------------------------------------------------------------------------
module pmfp_parser (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [pmfp_pkg::BYTE_W-1:0] rx_byte,
   output pmfp_pkg::frame_type         frame
);

   logic [pmfp_pkg::POS_W-1:0]  pos_ff,  pos_in;
   logic [pmfp_pkg::BYTE_W-1:0] csum_ff, csum_in;
   logic [pmfp_pkg::PM_W-1:0]   pm25_ff, pm25_in;
   logic [pmfp_pkg::PM_W-1:0]   pm10_ff, pm10_in;

   always_comb begin
      pos_in  = pos_ff;
      csum_in = csum_ff;
      pm25_in = pm25_ff;
      pm10_in = pm10_ff;
      if (accept) begin
         pos_in = pos_ff + 4'd1;
         case (pos_ff)
            pmfp_pkg::POS_HEADER: begin
               // drop anything but the header while hunting
               if (rx_byte == pmfp_pkg::FRAME_HEADER) begin
                  csum_in = '0;
                  pm25_in = '0;
                  pm10_in = '0;
               end else begin
                  pos_in = pmfp_pkg::POS_HEADER;
               end
            end
            pmfp_pkg::POS_PM25_LO: begin
               pm25_in[7:0] = rx_byte;
               csum_in      = csum_ff + rx_byte;
            end
            pmfp_pkg::POS_PM25_HI: begin
               pm25_in[15:8] = rx_byte;
               csum_in       = csum_ff + rx_byte;
            end
            pmfp_pkg::POS_PM10_LO: begin
               pm10_in[7:0] = rx_byte;
               csum_in      = csum_ff + rx_byte;
            end
            pmfp_pkg::POS_PM10_HI: begin
               pm10_in[15:8] = rx_byte;
               csum_in       = csum_ff + rx_byte;
            end
            pmfp_pkg::POS_ID_LO,
            pmfp_pkg::POS_ID_HI: begin
               csum_in = csum_ff + rx_byte;
            end
            pmfp_pkg::POS_CHECK: begin
               // zero afterwards exactly when the checksum byte matches
               csum_in = csum_ff ^ rx_byte;
            end
            pmfp_pkg::POS_TAIL: begin
               pos_in = pmfp_pkg::POS_HEADER;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= pmfp_pkg::POS_HEADER;
      end else begin
         pos_ff <= pos_in;
      end
      csum_ff <= csum_in;
      pm25_ff <= pm25_in;
      pm10_ff <= pm10_in;
   end

   assign frame.done = accept && (pos_ff == pmfp_pkg::POS_TAIL);
   assign frame.ok   = (csum_ff == '0);
   assign frame.pm25 = pm25_ff;
   assign frame.pm10 = pm10_ff;

endmodule

// ----- rtl/pmfp_ring.sv -----
// ---------------------------------------------------------------------------
// pmfp_ring: history ring and running sums
// Keeps the last DEPTH valid samples in a RAM and the sums of its entries.
// ---------------------------------------------------------------------------
module pmfp_ring #(
   parameter int DEPTH = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  pmfp_pkg::frame_type                    frame,
   output logic [pmfp_pkg::PM_W+$clog2(DEPTH)-1:0] pm25_sum,
   output logic [pmfp_pkg::PM_W+$clog2(DEPTH)-1:0] pm10_sum
);

   localparam int SUM_W = pmfp_pkg::PM_W + $clog2(DEPTH);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int ENT_W = 2 * pmfp_pkg::PM_W;

   logic [ENT_W-1:0] ring_mem [DEPTH];
   logic [ENT_W-1:0] old_ff;
   logic             old_valid_ff;
   logic [DEPTH-1:0] valid_ff, valid_in;
   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic [SUM_W-1:0] sum25_ff, sum25_in;
   logic [SUM_W-1:0] sum10_ff, sum10_in;
   logic [pmfp_pkg::PM_W-1:0] old25, old10;
   logic             store;

   assign store = frame.done && frame.ok;

   // entries never written since reset read as zero
   assign old25 = old_valid_ff ? old_ff[pmfp_pkg::PM_W-1:0] : '0;
   assign old10 = old_valid_ff ? old_ff[ENT_W-1:pmfp_pkg::PM_W] : '0;

   always_comb begin
      ptr_in   = ptr_ff;
      valid_in = valid_ff;
      sum25_in = sum25_ff;
      sum10_in = sum10_ff;
      if (store) begin
         ptr_in           = (ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : ptr_ff + 1'b1;
         valid_in[ptr_ff] = 1'b1;
         sum25_in         = sum25_ff - SUM_W'(old25) + SUM_W'(frame.pm25);
         sum10_in         = sum10_ff - SUM_W'(old10) + SUM_W'(frame.pm10);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff   <= '0;
         valid_ff <= '0;
         sum25_ff <= '0;
         sum10_ff <= '0;
      end else begin
         ptr_ff   <= ptr_in;
         valid_ff <= valid_in;
         sum25_ff <= sum25_in;
         sum10_ff <= sum10_in;
      end
   end

   // read ahead at the pointer; a frame lasts ten bytes, so the slot
   // data is settled long before the next store
   always_ff @(posedge clock) begin
      if (store) begin
         ring_mem[ptr_ff] <= {frame.pm10, frame.pm25};
      end
      old_ff       <= ring_mem[ptr_ff];
      old_valid_ff <= valid_ff[ptr_ff];
   end

   assign pm25_sum = sum25_in;
   assign pm10_sum = sum10_in;

endmodule

// ----- rtl/pmfp_mean.sv -----
// ---------------------------------------------------------------------------
// pmfp_mean: ring mean by constant reciprocal
// Computes (sum * 16) / DEPTH, truncated, with one multiply and a shift.
// ---------------------------------------------------------------------------
module pmfp_mean #(
   parameter int DEPTH = 8
) (
   input  logic [pmfp_pkg::PM_W+$clog2(DEPTH)-1:0] sum,
   output logic [pmfp_pkg::AVG_W-1:0]              average
);

   localparam int SUM_W = pmfp_pkg::PM_W + $clog2(DEPTH);
   localparam int N     = SUM_W + pmfp_pkg::FRAC_W;
   localparam int L     = $clog2(DEPTH);
   localparam int P_W   = 2 * N + 1;
   // floor(2^(N+L) / DEPTH) + 1 gives an exact quotient for any N-bit dividend
   localparam logic [N:0] RECIP = (N + 1)'(((64'd1 << (N + L)) / DEPTH) + 64'd1);

   logic [N-1:0]   dividend;
   logic [P_W-1:0] product;

   assign dividend = {sum, {pmfp_pkg::FRAC_W{1'b0}}};
   assign product  = P_W'(dividend) * P_W'(RECIP);
   assign average  = product[N + L +: pmfp_pkg::AVG_W];

endmodule

// ----- rtl/pm_sensor_frame_parser_avg_top.sv -----
// ---------------------------------------------------------------------------
// pm_sensor_frame_parser_avg_top: PM sensor frame parser with ring mean
// Parses ten-byte sensor frames and reports values, averages and status.
// ---------------------------------------------------------------------------
// One byte is taken per transfer, one per clock at full rate. Bytes other
// than the header 170 are dropped while hunting for a frame. The tenth byte
// of every frame yields one registered result: the frame's PM2.5 and
// PM10 in tenths (zero on a checksum mismatch), the means over the last
// HISTORY_DEPTH stored samples in tenths with 4 fraction bits, and the
// checksum status in tuser. The history sits in a RAM read ahead at the
// ring pointer, with a valid bit per entry cleared at reset, so no clearing
// pass is needed. The means come from running sums through one reciprocal
// multiply per value, between the frame stage and the output register.
// Input is held off only when both the frame stage and the output register
// hold results that the sink has not taken.
// ---------------------------------------------------------------------------
module pm_sensor_frame_parser_avg_top #(
   parameter int HISTORY_DEPTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [15:0] pm25_tenths, [31:16] pm10_tenths, [51:32] pm25_average,
   // [71:52] pm10_average
   output logic [71:0] rsp_tdata,
   output logic        rsp_tuser    // [0] checksum_ok
);

   localparam int SUM_W = pmfp_pkg::PM_W + $clog2(HISTORY_DEPTH);

   pmfp_pkg::frame_type frame;
   logic                req_accept;
   logic [SUM_W-1:0]    pm25_sum, pm10_sum;
   logic [pmfp_pkg::AVG_W-1:0] pm25_avg, pm10_avg;

   logic                      s1_valid_ff, s1_valid_in;
   logic                      s1_ok_ff;
   logic [pmfp_pkg::PM_W-1:0] s1_pm25_ff, s1_pm10_ff;
   logic [SUM_W-1:0]          s1_sum25_ff, s1_sum10_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [71:0]               rsp_data_ff;
   logic                      rsp_ok_ff;
   logic                      s2_load;

   assign s2_load    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s2_load;
   assign req_accept = req_tvalid && req_tready;

   pmfp_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_accept),
      .rx_byte (req_tdata),
      .frame   (frame)
   );

   pmfp_ring #(
      .DEPTH (HISTORY_DEPTH)
   ) u_ring (
      .clock    (clock),
      .reset    (reset),
      .frame    (frame),
      .pm25_sum (pm25_sum),
      .pm10_sum (pm10_sum)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (frame.done) begin
         s1_valid_in = 1'b1;
      end else if (s2_load) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s2_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // frame stage: hold the values and the sums after this frame
   always_ff @(posedge clock) begin
      if (frame.done) begin
         s1_ok_ff    <= frame.ok;
         s1_pm25_ff  <= frame.ok ? frame.pm25 : '0;
         s1_pm10_ff  <= frame.ok ? frame.pm10 : '0;
         s1_sum25_ff <= pm25_sum;
         s1_sum10_ff <= pm10_sum;
      end
   end

   pmfp_mean #(
      .DEPTH (HISTORY_DEPTH)
   ) u_mean25 (
      .sum     (s1_sum25_ff),
      .average (pm25_avg)
   );

   pmfp_mean #(
      .DEPTH (HISTORY_DEPTH)
   ) u_mean10 (
      .sum     (s1_sum10_ff),
      .average (pm10_avg)
   );

   always_ff @(posedge clock) begin
      if (s2_load) begin
         rsp_data_ff <= {pm10_avg, pm25_avg, s1_pm10_ff, s1_pm25_ff};
         rsp_ok_ff   <= s1_ok_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_ok_ff;

   // a dropped frame reports zero tenths
   a_bad_frame_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[31:0] == 32'd0))
      else $error("checksum failure with nonzero values");

   // a pending frame result is never overwritten or lost
   a_s1_hold : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s2_load) |=> (s1_valid_ff && $stable(s1_sum25_ff)))
      else $error("frame stage result lost");

   // input is held off only with both stages full
   a_backpressure : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s1_valid_ff && rsp_tvalid && !rsp_tready))
      else $error("input stalled without a full pipeline");

   // the means never exceed the largest possible sample
   a_avg_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[51:32] <= 20'hFFFF0) && (rsp_tdata[71:52] <= 20'hFFFF0)))
      else $error("ring mean out of range");

endmodule

// ----- tb/tb_pm_sensor_frame_parser_avg_top.sv -----
// ---------------------------------------------------------------------------
// tb_pm_sensor_frame_parser_avg_top: testbench of the PM sensor frame parser
// Drives sensor bytes into the parser, predicts every frame result from an
// independent parser and ring model, and checks each result transfer field
// by field. Both sides idle and stall at random. There is one long sink
// hold-off that fills the block, and one sender pause until all results
// have drained.
// ---------------------------------------------------------------------------
module tb_pm_sensor_frame_parser_avg_top;

   localparam int HISTORY_DEPTH = 8;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_CYCLES  = 20;
   localparam int RANDOM_ITEMS  = 400;

   typedef struct {
      logic [pmfp_pkg::PM_W-1:0]  pm25;
      logic [pmfp_pkg::PM_W-1:0]  pm10;
      logic [pmfp_pkg::AVG_W-1:0] avg25;
      logic [pmfp_pkg::AVG_W-1:0] avg10;
      logic                       ok;
   } frame_result_type;

   class pm_frame_scoreboard;
      logic [pmfp_pkg::POS_W-1:0]  byte_pos;
      logic [pmfp_pkg::BYTE_W-1:0] check_acc;
      logic [pmfp_pkg::PM_W-1:0]   cur25;
      logic [pmfp_pkg::PM_W-1:0]   cur10;
      logic [pmfp_pkg::PM_W-1:0]   ring25 [HISTORY_DEPTH];
      logic [pmfp_pkg::PM_W-1:0]   ring10 [HISTORY_DEPTH];
      int unsigned                 slot;
      int unsigned                 sum25;
      int unsigned                 sum10;
      frame_result_type            expected_q [$];
      int                          errors;

      function new();
         byte_pos  = pmfp_pkg::POS_HEADER;
         check_acc = '0;
         cur25     = '0;
         cur10     = '0;
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            ring25[i] = '0;
            ring10[i] = '0;
         end
         slot   = 0;
         sum25  = 0;
         sum10  = 0;
         errors = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function logic [pmfp_pkg::AVG_W-1:0] ring_average(int unsigned s);
         int unsigned scaled;
         scaled = (s << pmfp_pkg::FRAC_W) / HISTORY_DEPTH;
         return scaled[pmfp_pkg::AVG_W-1:0];
      endfunction

      function void note_input(logic [pmfp_pkg::BYTE_W-1:0] b);
         frame_result_type r;
         if (byte_pos == pmfp_pkg::POS_HEADER) begin
            // drop anything but the header while hunting
            if (b != pmfp_pkg::FRAME_HEADER) return;
            check_acc = '0;
            cur25     = '0;
            cur10     = '0;
         end
         if (byte_pos >= pmfp_pkg::POS_PM25_LO && byte_pos <= pmfp_pkg::POS_ID_HI) begin
            check_acc += b;
         end
         case (byte_pos)
            pmfp_pkg::POS_PM25_LO: cur25[7:0]  = b;
            pmfp_pkg::POS_PM25_HI: cur25[15:8] = b;
            pmfp_pkg::POS_PM10_LO: cur10[7:0]  = b;
            pmfp_pkg::POS_PM10_HI: cur10[15:8] = b;
            pmfp_pkg::POS_CHECK:   check_acc  ^= b;
            default: ;
         endcase
         if (byte_pos != pmfp_pkg::POS_TAIL) begin
            byte_pos++;
            return;
         end
         byte_pos = pmfp_pkg::POS_HEADER;
         r.ok = (check_acc == '0);
         if (r.ok) begin
            sum25        = sum25 - ring25[slot] + cur25;
            sum10        = sum10 - ring10[slot] + cur10;
            ring25[slot] = cur25;
            ring10[slot] = cur10;
            slot         = (slot + 1) % HISTORY_DEPTH;
            r.pm25       = cur25;
            r.pm10       = cur10;
         end else begin
            r.pm25 = '0;
            r.pm10 = '0;
         end
         r.avg25 = ring_average(sum25);
         r.avg10 = ring_average(sum10);
         expected_q.push_back(r);
      endfunction

      function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
         if (exp_v !== act_v) begin
            errors++;
            $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, name, exp_v, act_v);
         end
      endfunction

      function void check_result(logic [71:0] data, logic user);
         frame_result_type e;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result: expected none, actual %h / %b", $time, data, user);
            return;
         end
         e = expected_q.pop_front();
         compare_field("pm25_tenths",  e.pm25,  data[15:0]);
         compare_field("pm10_tenths",  e.pm10,  data[31:16]);
         compare_field("pm25_average", e.avg25, data[51:32]);
         compare_field("pm10_average", e.avg10, data[71:52]);
         compare_field("checksum_ok",  e.ok,    user);
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready;
   // [15:0] pm25_tenths, [31:16] pm10_tenths, [51:32] pm25_average,
   // [71:52] pm10_average
   logic [71:0] rsp_tdata;
   logic        rsp_tuser;   // [0] checksum_ok

   logic        hold_req;
   bit          tx_burst;
   int          cycle_count;

   pm_frame_scoreboard sb = new();

   pm_sensor_frame_parser_avg_top #(.HISTORY_DEPTH(HISTORY_DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
   end

   // sink: short stalls, rare long ones, quiet stretches and one long hold-off
   initial begin
      int stall_left;
      int quiet_left;
      int hold_left;
      logic hold_seen;
      stall_left = 0;
      quiet_left = 0;
      hold_left  = 0;
      hold_seen  = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (quiet_left > 0) quiet_left--;
            else if ($urandom_range(0, 199) == 0) quiet_left = $urandom_range(50, 150);
            else if ($urandom_range(0, 9) == 0)
               stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(1, 3);
         end
      end
   end

   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (tx_burst || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function logic [pmfp_pkg::PM_W-1:0] pick_pm();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         default: return 16'($urandom);
      endcase
   endfunction

   task send_byte(input logic [pmfp_pkg::BYTE_W-1:0] b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      sb.note_input(b);
   endtask

   task send_frame(input logic [pmfp_pkg::PM_W-1:0] pm25,
                   input logic [pmfp_pkg::PM_W-1:0] pm10,
                   input logic [pmfp_pkg::PM_W-1:0] id,
                   input logic [pmfp_pkg::BYTE_W-1:0] cmd,
                   input logic [pmfp_pkg::BYTE_W-1:0] tail, input bit corrupt);
      logic [pmfp_pkg::BYTE_W-1:0] sum;
      sum = pm25[7:0] + pm25[15:8] + pm10[7:0] + pm10[15:8] + id[7:0] + id[15:8];
      if (corrupt) sum ^= 8'($urandom_range(1, 255));
      send_byte(pmfp_pkg::FRAME_HEADER);
      send_byte(cmd);
      send_byte(pm25[7:0]);
      send_byte(pm25[15:8]);
      send_byte(pm10[7:0]);
      send_byte(pm10[15:8]);
      send_byte(id[7:0]);
      send_byte(id[15:8]);
      send_byte(sum);
      send_byte(tail);
   endtask

   task send_random_frame(input bit corrupt);
      send_frame(pick_pm(), pick_pm(), 16'($urandom), 8'($urandom), 8'($urandom), corrupt);
   endtask

   task wait_for_results();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   initial begin
      int sent;
      int frame_no;
      int kind;
      int k;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      rsp_tready  = 1'b0;
      hold_req    = 1'b0;
      tx_burst    = 1'b0;
      cycle_count = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // noise while hunting, header values inside a frame, extremes,
      // then a checksum mismatch
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h55);
      send_frame({pmfp_pkg::FRAME_HEADER, pmfp_pkg::FRAME_HEADER}, 16'hFFFF,
                 {pmfp_pkg::FRAME_HEADER, 8'h00}, pmfp_pkg::FRAME_HEADER, 8'hFF, 1'b0);
      send_frame(16'h0000, 16'hFFFF, 16'h00FF, 8'h00, 8'h00, 1'b1);

      sent     = 0;
      frame_no = 0;
      while (sent < RANDOM_ITEMS) begin
         frame_no++;
         if (frame_no % 8 == 0) tx_burst = ($urandom_range(0, 2) == 0);
         if (frame_no == 12) wait_for_results();
         if (frame_no == 24) begin
            // stall the sink long enough that the block backs up into the input
            hold_req <= ~hold_req;
            tx_burst = 1'b1;
            repeat (6) send_random_frame(1'b0);
            tx_burst = 1'b0;
            sent += 60;
         end
         kind = $urandom_range(0, 99);
         if (kind < 75) begin
            send_random_frame(1'b0);
            sent += 10;
         end else if (kind < 85) begin
            send_random_frame(1'b1);
            sent += 10;
         end else if (kind < 93) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
         end else begin
            // cut a frame short; the next frame's bytes run on as its data
            k = $urandom_range(1, 8);
            send_byte(pmfp_pkg::FRAME_HEADER);
            repeat (k) send_byte(8'($urandom));
            sent += k + 1;
         end
      end

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
